@@ rtl/core/clksw_pkg.sv @@
// ----------------------------------------------------------------------------
// clksw_pkg
// Types and constants for the twelve-hour clock and stopwatch counter.
// ----------------------------------------------------------------------------
package clksw_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_MODE = 2'd1,
        CMD_SET  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_TICKS_PER_SECOND      = 2'd0,
        CFG_TICKS_PER_CENTISECOND = 2'd1,
        CFG_LONG_PRESS_TICKS      = 2'd2
    } t_cfg_idx;

    localparam int CFG_DATA_W = 12;

    localparam logic [9:0]  TPS_RESET  = 10'd1000;
    localparam logic [3:0]  TPC_RESET  = 4'd10;
    localparam logic [11:0] LPT_RESET  = 12'd2010;
    localparam logic [11:0] PRESS_MAX  = 12'd4095;

    localparam logic [3:0]  HOUR_RESET   = 4'd2;
    localparam logic [5:0]  MINUTE_RESET = 6'd30;
    localparam logic [5:0]  SECOND_RESET = 6'd10;

    typedef struct packed {
        logic [9:0]  ms_count;
        logic [3:0]  centi_tick_count;
        logic [11:0] press_ticks;
        logic        press_active;
        logic        press_consumed;
        logic [3:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [5:0]  clock_second;
        logic        pm_flag;
        logic        view_mode;
        logic        run_flag;
        logic [4:0]  sw_hours;
        logic [5:0]  sw_minutes;
        logic [5:0]  sw_seconds;
        logic [6:0]  sw_centis;
    } t_state;

endpackage

@@ rtl/core/clock_and_stopwatch_counter_top.sv @@
// ----------------------------------------------------------------------------
// clock_and_stopwatch_counter_top
// Throughput: one item per cycle while the output is not stalled; one input
// register and the state/result register, with the update logic between them.
// Reset (synchronous, active low) clears the valids, restores the clock to
// 2:30:10 PM, clears the stopwatch and restores register defaults.
// ----------------------------------------------------------------------------
module clock_and_stopwatch_counter_top import clksw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_cmd,
    input  logic                  i_button_down,
    input  logic [4:0]            i_set_hour,
    input  logic [5:0]            i_set_minute,
    input  logic [5:0]            i_set_second,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_clock_hour_out,
    output logic [5:0]            o_clock_minute_out,
    output logic [5:0]            o_clock_second_out,
    output logic                  o_is_pm,
    output logic [4:0]            o_sw_hours_out,
    output logic [5:0]            o_sw_minutes_out,
    output logic [5:0]            o_sw_seconds_out,
    output logic [6:0]            o_sw_centis_out,
    output logic                  o_showing_stopwatch,
    output logic                  o_running
);

    logic [9:0]  r_tps;
    logic [3:0]  r_tpc;
    logic [11:0] r_lpt;

    logic        r_in_valid;
    t_cmd        r_in_cmd;
    logic        r_in_button;
    logic [4:0]  r_in_hour;
    logic [5:0]  r_in_minute;
    logic [5:0]  r_in_second;

    logic        r_out_valid;
    t_state      r_st;
    t_state      n_st;

    logic        advance;
    logic        in_xfer;

    logic [10:0] ms_inc;
    logic [4:0]  ct_inc;
    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [4:0]  hr_inc;
    logic [7:0]  cs_inc;
    logic [6:0]  sws_inc;
    logic [6:0]  swm_inc;
    logic [5:0]  swh_inc;
    logic [11:0] pt_base;
    logic [11:0] pt_next;
    logic        consumed_base;
    logic [4:0]  set_h;
    logic [5:0]  set_m;
    logic [5:0]  set_s;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_xfer = i_valid && !o_stall;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
            r_tpc <= TPC_RESET;
            r_lpt <= LPT_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TICKS_PER_SECOND:      r_tps <= i_cfg_data[9:0];
                CFG_TICKS_PER_CENTISECOND: r_tpc <= i_cfg_data[3:0];
                CFG_LONG_PRESS_TICKS:      r_lpt <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd    <= t_cmd'(i_cmd);
            r_in_button <= i_button_down;
            r_in_hour   <= i_set_hour;
            r_in_minute <= i_set_minute;
            r_in_second <= i_set_second;
        end
    end

    // state update
    always_comb begin
        n_st          = r_st;
        ms_inc        = {1'b0, r_st.ms_count} + 11'd1;
        ct_inc        = {1'b0, r_st.centi_tick_count} + 5'd1;
        sec_inc       = {1'b0, r_st.clock_second} + 7'd1;
        min_inc       = {1'b0, r_st.clock_minute} + 7'd1;
        hr_inc        = {1'b0, r_st.clock_hour} + 5'd1;
        cs_inc        = {1'b0, r_st.sw_centis} + 8'd1;
        sws_inc       = {1'b0, r_st.sw_seconds} + 7'd1;
        swm_inc       = {1'b0, r_st.sw_minutes} + 7'd1;
        swh_inc       = {1'b0, r_st.sw_hours} + 6'd1;
        pt_base       = r_st.press_active ? r_st.press_ticks : 12'd0;
        consumed_base = r_st.press_active ? r_st.press_consumed : 1'b0;
        pt_next       = (pt_base < PRESS_MAX) ? pt_base + 12'd1 : pt_base;
        set_h         = (r_in_hour > 5'd23) ? 5'd23 : r_in_hour;
        set_m         = (r_in_minute > 6'd59) ? 6'd59 : r_in_minute;
        set_s         = (r_in_second > 6'd59) ? 6'd59 : r_in_second;

        case (r_in_cmd)
            CMD_TICK: begin
                if (ms_inc >= {1'b0, r_tps}) begin
                    n_st.ms_count = 10'd0;
                    if (sec_inc < 7'd60) begin
                        n_st.clock_second = sec_inc[5:0];
                    end else begin
                        n_st.clock_second = 6'd0;
                        if (min_inc < 7'd60) begin
                            n_st.clock_minute = min_inc[5:0];
                        end else begin
                            n_st.clock_minute = 6'd0;
                            if (hr_inc == 5'd12) begin
                                n_st.clock_hour = 4'd12;
                                n_st.pm_flag    = !r_st.pm_flag;
                            end else if (hr_inc >= 5'd13) begin
                                n_st.clock_hour = 4'd1;
                            end else begin
                                n_st.clock_hour = hr_inc[3:0];
                            end
                        end
                    end
                end else begin
                    n_st.ms_count = ms_inc[9:0];
                end

                if (r_st.run_flag) begin
                    if (ct_inc >= {1'b0, r_tpc}) begin
                        n_st.centi_tick_count = 4'd0;
                        if (cs_inc < 8'd100) begin
                            n_st.sw_centis = cs_inc[6:0];
                        end else begin
                            n_st.sw_centis = 7'd0;
                            if (sws_inc < 7'd60) begin
                                n_st.sw_seconds = sws_inc[5:0];
                            end else begin
                                n_st.sw_seconds = 6'd0;
                                if (swm_inc < 7'd60) begin
                                    n_st.sw_minutes = swm_inc[5:0];
                                end else begin
                                    n_st.sw_minutes = 6'd0;
                                    n_st.sw_hours   = (swh_inc >= 6'd24) ? 5'd0
                                                                         : swh_inc[4:0];
                                end
                            end
                        end
                    end else begin
                        n_st.centi_tick_count = ct_inc[3:0];
                    end
                end

                if (r_in_button) begin
                    n_st.press_active   = 1'b1;
                    n_st.press_ticks    = pt_next;
                    n_st.press_consumed = consumed_base;
                    if (!consumed_base && (pt_next > r_lpt)) begin
                        n_st.sw_hours       = 5'd0;
                        n_st.sw_minutes     = 6'd0;
                        n_st.sw_seconds     = 6'd0;
                        n_st.sw_centis      = 7'd0;
                        n_st.run_flag       = 1'b0;
                        n_st.press_consumed = 1'b1;
                    end
                end else if (r_st.press_active) begin
                    if (!r_st.press_consumed) begin
                        n_st.run_flag = !r_st.run_flag;
                    end
                    n_st.press_active   = 1'b0;
                    n_st.press_consumed = 1'b0;
                    n_st.press_ticks    = 12'd0;
                end
            end
            CMD_MODE: begin
                n_st.view_mode = !r_st.view_mode;
            end
            CMD_SET: begin
                if (set_h >= 5'd12) begin
                    n_st.pm_flag    = 1'b1;
                    n_st.clock_hour = (set_h > 5'd12) ? 4'(set_h - 5'd12) : 4'(set_h);
                end else begin
                    n_st.pm_flag    = 1'b0;
                    n_st.clock_hour = (set_h == 5'd0) ? 4'd12 : set_h[3:0];
                end
                n_st.clock_minute = set_m;
                n_st.clock_second = set_s;
            end
            default: ;
        endcase
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_st        <= '{
                ms_count:         10'd0,
                centi_tick_count: 4'd0,
                press_ticks:      12'd0,
                press_active:     1'b0,
                press_consumed:   1'b0,
                clock_hour:       HOUR_RESET,
                clock_minute:     MINUTE_RESET,
                clock_second:     SECOND_RESET,
                pm_flag:          1'b1,
                view_mode:        1'b0,
                run_flag:         1'b0,
                sw_hours:         5'd0,
                sw_minutes:       6'd0,
                sw_seconds:       6'd0,
                sw_centis:        7'd0
            };
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_clock_hour_out    = r_st.clock_hour;
    assign o_clock_minute_out  = r_st.clock_minute;
    assign o_clock_second_out  = r_st.clock_second;
    assign o_is_pm             = r_st.pm_flag;
    assign o_sw_hours_out      = r_st.sw_hours;
    assign o_sw_minutes_out    = r_st.sw_minutes;
    assign o_sw_seconds_out    = r_st.sw_seconds;
    assign o_sw_centis_out     = r_st.sw_centis;
    assign o_showing_stopwatch = r_st.view_mode;
    assign o_running           = r_st.run_flag;

endmodule

@@ dv/clksw_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// clksw_tb_pkg
// Display tracker for the clock and stopwatch testbench: keeps its own copy
// of the registers and counters, works out the display that each accepted
// item should produce, and compares returned displays in order.
// ----------------------------------------------------------------------------
package clksw_tb_pkg;

    import clksw_pkg::*;

    localparam bit [1:0] CMD_UNUSED = 2'd3;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [3:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       pm;
        logic [4:0] sw_hours;
        logic [5:0] sw_minutes;
        logic [5:0] sw_seconds;
        logic [6:0] sw_centis;
        logic       view;
        logic       run;
    } t_display;

    class display_tracker;

        bit [9:0]  tps;
        bit [3:0]  tpc;
        bit [11:0] lpt;

        bit [9:0]  ms_count;
        bit [3:0]  centi_count;
        bit [11:0] hold_ticks;
        bit        hold_active;
        bit        hold_spent;
        bit [3:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  second;
        bit        pm;
        bit        view;
        bit        run;
        bit [4:0]  sw_hours;
        bit [5:0]  sw_minutes;
        bit [5:0]  sw_seconds;
        bit [6:0]  sw_centis;

        t_display  awaited[$];
        int        noted;
        int        checked;
        int        errors;

        function new();
            tps         = TPS_RESET;
            tpc         = TPC_RESET;
            lpt         = LPT_RESET;
            ms_count    = '0;
            centi_count = '0;
            hold_ticks  = '0;
            hold_active = 1'b0;
            hold_spent  = 1'b0;
            hour        = HOUR_RESET;
            minute      = MINUTE_RESET;
            second      = SECOND_RESET;
            pm          = 1'b1;
            view        = 1'b0;
            run         = 1'b0;
            sw_hours    = '0;
            sw_minutes  = '0;
            sw_seconds  = '0;
            sw_centis   = '0;
            noted       = 0;
            checked     = 0;
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_TICKS_PER_SECOND:      tps = value[9:0];
                CFG_TICKS_PER_CENTISECOND: tpc = value[3:0];
                CFG_LONG_PRESS_TICKS:      lpt = value[11:0];
                default: ;
            endcase
        endfunction

        function void note_item(bit [1:0] cmd, bit down, bit [4:0] h, bit [5:0] m,
                                bit [5:0] s);
            bit [4:0] hh;
            bit       was_running;
            was_running = run;
            hh = (h > 5'd23) ? 5'd23 : h;
            if (cmd == CMD_TICK) begin
                ms_count = ms_count + 10'd1;
                if (ms_count >= tps) begin
                    ms_count = '0;
                    second = second + 6'd1;
                    if (second >= 6'd60) begin
                        second = '0;
                        minute = minute + 6'd1;
                        if (minute >= 6'd60) begin
                            minute = '0;
                            hour = hour + 4'd1;
                            if (hour == 4'd12) begin
                                pm = ~pm;
                            end else if (hour >= 4'd13) begin
                                hour = 4'd1;
                            end
                        end
                    end
                end
                if (was_running) begin
                    centi_count = centi_count + 4'd1;
                    if (centi_count >= tpc) begin
                        centi_count = '0;
                        sw_centis = sw_centis + 7'd1;
                        if (sw_centis >= 7'd100) begin
                            sw_centis = '0;
                            sw_seconds = sw_seconds + 6'd1;
                            if (sw_seconds >= 6'd60) begin
                                sw_seconds = '0;
                                sw_minutes = sw_minutes + 6'd1;
                                if (sw_minutes >= 6'd60) begin
                                    sw_minutes = '0;
                                    sw_hours = sw_hours + 5'd1;
                                    if (sw_hours >= 5'd24) begin
                                        sw_hours = '0;
                                    end
                                end
                            end
                        end
                    end
                end
                if (down) begin
                    if (!hold_active) begin
                        hold_active = 1'b1;
                        hold_spent  = 1'b0;
                        hold_ticks  = '0;
                    end
                    if (hold_ticks != PRESS_MAX) begin
                        hold_ticks = hold_ticks + 12'd1;
                    end
                    if (!hold_spent && hold_ticks > lpt) begin
                        sw_hours   = '0;
                        sw_minutes = '0;
                        sw_seconds = '0;
                        sw_centis  = '0;
                        run        = 1'b0;
                        hold_spent = 1'b1;
                    end
                end else if (hold_active) begin
                    if (!hold_spent) begin
                        run = ~run;
                    end
                    hold_active = 1'b0;
                    hold_spent  = 1'b0;
                    hold_ticks  = '0;
                end
            end else if (cmd == CMD_MODE) begin
                view = ~view;
            end else if (cmd == CMD_SET) begin
                if (hh >= 5'd12) begin
                    pm   = 1'b1;
                    hour = (hh > 5'd12) ? 4'(hh - 5'd12) : 4'(hh);
                end else begin
                    pm   = 1'b0;
                    hour = (hh == 5'd0) ? 4'd12 : 4'(hh);
                end
                minute = (m > 6'd59) ? 6'd59 : m;
                second = (s > 6'd59) ? 6'd59 : s;
            end
            awaited.push_back({hour, minute, second, pm, sw_hours, sw_minutes, sw_seconds,
                               sw_centis, view, run});
            noted++;
        endfunction

        function string show(t_display d);
            return $sformatf("%0d:%0d:%0d pm=%0d sw=%0d:%0d:%0d.%0d view=%0d run=%0d",
                             d.hour, d.minute, d.second, d.pm, d.sw_hours, d.sw_minutes,
                             d.sw_seconds, d.sw_centis, d.view, d.run);
        endfunction

        function void check_display(t_display got);
            t_display want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb: result with nothing pending: %s", show(got));
                end
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb: result %0d wrong: expected %s, got %s", checked,
                             show(want), show(got));
                end
            end
        endfunction

    endclass

endpackage

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for clock_and_stopwatch_counter_top. Drives ticks, mode presses
// and set-time items across several register settings and idling patterns,
// and checks every display against the tracker's own prediction.
// ----------------------------------------------------------------------------
module tb;

    import clksw_pkg::*;
    import clksw_tb_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_cmd;
    logic                  i_button_down;
    logic [4:0]            i_set_hour;
    logic [5:0]            i_set_minute;
    logic [5:0]            i_set_second;
    logic                  o_valid;
    logic                  i_stall;
    logic [3:0]            o_clock_hour_out;
    logic [5:0]            o_clock_minute_out;
    logic [5:0]            o_clock_second_out;
    logic                  o_is_pm;
    logic [4:0]            o_sw_hours_out;
    logic [5:0]            o_sw_minutes_out;
    logic [5:0]            o_sw_seconds_out;
    logic [6:0]            o_sw_centis_out;
    logic                  o_showing_stopwatch;
    logic                  o_running;

    t_display       seen;
    int             sender_gap_pct = 0;
    int             stall_pct = 0;
    int             settings_used = 1;
    display_tracker tracker = new();

    clock_and_stopwatch_counter_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_cmd               (i_cmd),
        .i_button_down       (i_button_down),
        .i_set_hour          (i_set_hour),
        .i_set_minute        (i_set_minute),
        .i_set_second        (i_set_second),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_clock_hour_out    (o_clock_hour_out),
        .o_clock_minute_out  (o_clock_minute_out),
        .o_clock_second_out  (o_clock_second_out),
        .o_is_pm             (o_is_pm),
        .o_sw_hours_out      (o_sw_hours_out),
        .o_sw_minutes_out    (o_sw_minutes_out),
        .o_sw_seconds_out    (o_sw_seconds_out),
        .o_sw_centis_out     (o_sw_centis_out),
        .o_showing_stopwatch (o_showing_stopwatch),
        .o_running           (o_running)
    );

    assign seen = {o_clock_hour_out, o_clock_minute_out, o_clock_second_out, o_is_pm,
                   o_sw_hours_out, o_sw_minutes_out, o_sw_seconds_out, o_sw_centis_out,
                   o_showing_stopwatch, o_running};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_display(seen);
        end
    end

    task automatic send_item(bit [1:0] cmd, bit down, bit [4:0] h, bit [5:0] m,
                             bit [5:0] s);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_button_down <= down;
        i_set_hour    <= h;
        i_set_minute  <= m;
        i_set_second  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_item(cmd, down, h, m, s);
        @(negedge i_clk);
    endtask

    task automatic send_random(bit [1:0] cmd, bit down);
        send_item(cmd, down, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic retune(bit [9:0] tps, bit [3:0] tpc, bit [11:0] lpt, t_idle_mode mode);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_TICKS_PER_SECOND;
        i_cfg_data  <= CFG_DATA_W'(tps);
        @(negedge i_clk);
        i_cfg_index <= CFG_TICKS_PER_CENTISECOND;
        i_cfg_data  <= CFG_DATA_W'(tpc);
        @(negedge i_clk);
        i_cfg_index <= CFG_LONG_PRESS_TICKS;
        i_cfg_data  <= CFG_DATA_W'(lpt);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.set_reg(CFG_TICKS_PER_SECOND, CFG_DATA_W'(tps));
        tracker.set_reg(CFG_TICKS_PER_CENTISECOND, CFG_DATA_W'(tpc));
        tracker.set_reg(CFG_LONG_PRESS_TICKS, CFG_DATA_W'(lpt));
        settings_used++;
        case (mode)
            IDLE_NONE: begin
                sender_gap_pct = 0;
                stall_pct     <= 0;
            end
            IDLE_SENDER: begin
                sender_gap_pct = 47;
                stall_pct     <= 0;
            end
            IDLE_RECEIVER: begin
                sender_gap_pct = 0;
                stall_pct     <= 47;
            end
            default: begin
                sender_gap_pct = 33;
                stall_pct     <= 33;
            end
        endcase
    endtask

    // Mostly button presses and tick runs; presses hover around the hold limit
    // when it is short, with the odd mode or set-time transfer mid-hold.
    task automatic random_items(int count);
        int n;
        int pick;
        int len;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_random(CMD_SET, 1'($urandom_range(0, 1)));
                n++;
            end else if (pick < 11) begin
                send_random(CMD_MODE, 1'($urandom_range(0, 1)));
                n++;
            end else if (pick < 13) begin
                send_random(CMD_UNUSED, 1'($urandom_range(0, 1)));
                n++;
            end else if (pick < 45) begin
                if (tracker.lpt <= 12'd64 && $urandom_range(0, 2) == 0) begin
                    len = int'(tracker.lpt) + int'($urandom_range(0, 3)) - 1;
                    if (len < 1) begin
                        len = 1;
                    end
                end else begin
                    len = $urandom_range(1, 6);
                end
                repeat (len) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_random(($urandom_range(0, 1) != 0) ? CMD_MODE : CMD_SET, 1'b1);
                    end
                    send_random(CMD_TICK, 1'b1);
                end
                send_random(CMD_TICK, 1'b0);
                n += len + 1;
            end else begin
                len = $urandom_range(1, 12);
                repeat (len) send_random(CMD_TICK, 1'b0);
                n += len;
            end
        end
    endtask

    initial begin
        int phase;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_TICKS_PER_SECOND;
        i_cfg_data    <= '0;
        i_cmd         <= CMD_TICK;
        i_button_down <= 1'b0;
        i_set_hour    <= '0;
        i_set_minute  <= '0;
        i_set_second  <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, no idling
        send_item(CMD_TICK, 1'b0, 5'd0, 6'd0, 6'd0);
        send_item(CMD_MODE, 1'b0, 5'd0, 6'd0, 6'd0);
        send_item(CMD_MODE, 1'b1, 5'd0, 6'd0, 6'd0);
        send_item(CMD_UNUSED, 1'b1, 5'h1f, 6'h3f, 6'h3f);
        random_items(200);

        // one tick per second and centisecond: carries, set-time edges, presses
        retune(10'd1, 4'd1, 12'd3, IDLE_NONE);
        send_item(CMD_SET, 1'b0, 5'd0, 6'd0, 6'd0);
        send_item(CMD_SET, 1'b0, 5'd12, 6'd0, 6'd0);
        send_item(CMD_SET, 1'b0, 5'd13, 6'd5, 6'd7);
        send_item(CMD_SET, 1'b1, 5'd31, 6'd63, 6'd63);
        send_item(CMD_SET, 1'b0, 5'd23, 6'd59, 6'd59);
        send_random(CMD_TICK, 1'b0);
        send_item(CMD_SET, 1'b0, 5'd11, 6'd59, 6'd59);
        send_random(CMD_TICK, 1'b0);
        send_item(CMD_SET, 1'b0, 5'd12, 6'd59, 6'd59);
        send_random(CMD_TICK, 1'b0);
        send_random(CMD_TICK, 1'b1);
        send_random(CMD_TICK, 1'b0);
        repeat (2) send_random(CMD_TICK, 1'b0);
        repeat (5) send_random(CMD_TICK, 1'b1);
        send_random(CMD_TICK, 1'b0);
        send_random(CMD_TICK, 1'b1);
        send_random(CMD_MODE, 1'b0);
        send_random(CMD_TICK, 1'b1);
        send_random(CMD_TICK, 1'b0);
        random_items(250);

        // widest settings
        retune(10'd1023, 4'd15, 12'd4095, IDLE_RECEIVER);
        random_items(200);

        retune(10'd0, 4'd0, 12'd0, IDLE_SENDER);
        random_items(200);

        // long stopwatch run to carry into seconds
        retune(10'd7, 4'd1, 12'd20, IDLE_BOTH);
        random_items(200);
        if (!tracker.run) begin
            send_random(CMD_TICK, 1'b1);
            send_random(CMD_TICK, 1'b0);
        end
        repeat (300) send_random(CMD_TICK, 1'b0);

        for (phase = 0; phase < 3; phase++) begin
            retune(10'($urandom_range(1, 40)), 4'($urandom_range(1, 15)),
                   12'($urandom_range(1, 50)), t_idle_mode'(phase + 1));
            random_items(150);
        end

        drain();
        $display("tb: %0d transfers in, %0d displays checked, %0d register settings",
                 tracker.noted, tracker.checked, settings_used);
        $display("tb: covered clock and stopwatch carries, set-time clamping, long holds");
        if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/clksw_pkg.sv
rtl/core/clock_and_stopwatch_counter_top.sv
dv/clksw_tb_pkg.sv
dv/tb.sv
